[hdl/radix_number_to_ascii_core_assert.svh]
// Assertion macros for the radix-to-ASCII converter RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef RADIX_NUMBER_TO_ASCII_CORE_ASSERT_SVH
`define RADIX_NUMBER_TO_ASCII_CORE_ASSERT_SVH

// checked only outside reset
`define RNA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RNA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/rna_pkg.sv]
// Package for the radix-to-ASCII converter: sequencer states, divider status,
// character codes and digit tables. No dependencies.
package rna_pkg;

  // quotient bits resolved per divider cycle
  localparam int RNA_DIV_STEP = 4;

  localparam logic [7:0] RADIX_MIN = 8'd2;
  localparam logic [7:0] RADIX_MAX = 8'd16;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [7:0] DIGIT_UPPER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };
  localparam logic [7:0] DIGIT_LOWER [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SIGN,
    ST_PRE0,
    ST_PRE1,
    ST_PAD,
    ST_DIG
  } rna_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rna_div_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    return upper ? DIGIT_UPPER[d] : DIGIT_LOWER[d];
  endfunction

endpackage

[hdl/rna_divider.sv]
// Iterative divider: VALUE_BITS-bit dividend by a 2..16 base, four quotient
// bits per cycle (restoring). Depends on rna_pkg.
module rna_divider #(
  parameter int VALUE_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VALUE_BITS-1:0]   dividend,
  input  logic [4:0]              divisor,
  output logic [VALUE_BITS-1:0]   quotient,
  output logic [3:0]              remainder,
  output rna_pkg::rna_div_stat_t  stat
);
  import rna_pkg::*;

  localparam int PW   = ((VALUE_BITS + RNA_DIV_STEP - 1) / RNA_DIV_STEP) * RNA_DIV_STEP;
  localparam int ITER = PW / RNA_DIV_STEP;
  localparam int CNTW = $clog2(ITER + 1);

  logic [PW-1:0]   dv_r, dv_nxt;
  logic [3:0]      rem_r, rem_nxt;
  logic [4:0]      base_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;

  // one restoring step per quotient bit; remainder stays below the base
  always_comb begin
    logic [4:0]    t;
    logic [3:0]    r;
    logic [PW-1:0] d;
    r = rem_r;
    d = dv_r;
    for (int i = 0; i < RNA_DIV_STEP; i++) begin
      t = {r, d[PW-1]};
      if (t >= base_r) begin
        t = t - base_r;
        d = {d[PW-2:0], 1'b1};
      end else begin
        d = {d[PW-2:0], 1'b0};
      end
      r = t[3:0];
    end
    dv_nxt  = d;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(ITER);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r   <= PW'(dividend);
      rem_r  <= '0;
      base_r <= divisor;
    end else if (busy_r) begin
      dv_r  <= dv_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = dv_r[VALUE_BITS-1:0];
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[hdl/radix_number_to_ascii_core.sv]
// Radix number to ASCII converter, top level. Depends on rna_pkg, rna_divider
// and radix_number_to_ascii_core_assert.svh.
// One transaction in gives the text of one number out, one character per
// transaction, most significant first, last character flagged; an invalid base
// gives a single NUL character with bad_radix set. The block takes a new number
// only when the previous text has been fully handed to the output register.
// The shared divider resolves four quotient bits per cycle. Each digit takes a
// start step, the divider steps and a step that stores the digit. The sign, the
// two prefix characters, the padding characters and the digits then follow in
// that order, each emitted when the output register can take it.
module radix_number_to_ascii_core #(
  parameter int VALUE_BITS = 32,
  parameter int MAX_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_value,
  input  logic [7:0]  in_radix,
  input  logic        in_signed_mode,
  input  logic [7:0]  in_min_width,
  input  logic        in_show_prefix,
  input  logic        in_zero_fill,
  input  logic        in_force_plus,
  input  logic        in_upper_digits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_last_char,
  output logic        out_bad_radix
);
  import rna_pkg::*;

  `include "radix_number_to_ascii_core_assert.svh"

  localparam int MAXV = (VALUE_BITS > MAX_WIDTH) ? VALUE_BITS : MAX_WIDTH;
  localparam int CW   = $clog2(MAXV + 1);
  localparam int DI   = $clog2(VALUE_BITS);

  rna_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] mag_r;
  logic [4:0]            base_r;
  logic                  sign_en_r;
  logic [7:0]            sign_ch_r;
  logic                  pre_en_r;
  logic [7:0]            pre_ch_r;
  logic                  zfill_r;
  logic                  upper_r;
  logic [CW-1:0]         width_r;
  logic [CW-1:0]         nd_r;
  logic [3:0]            dig_r [VALUE_BITS];

  logic                  out_valid_r;
  logic [7:0]            char_r;
  logic                  last_r;
  logic                  bad_r;

  logic                  accept, ld;
  logic                  emit_vld, emit_last, emit_bad;
  logic [7:0]            emit_ch;
  logic [VALUE_BITS-1:0] in_mag, div_q;
  logic [3:0]            div_rem;
  logic                  in_neg, in_bad;
  logic [7:0]            in_wclamp;
  logic [DI-1:0]         rd_idx;
  rna_div_stat_t         div_stat;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign ld       = !out_valid_r || out_ready;

  assign in_bad    = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
  assign in_neg    = in_signed_mode && in_value[VALUE_BITS-1];
  assign in_mag    = in_neg ? (~in_value[VALUE_BITS-1:0] + VALUE_BITS'(1))
                            : in_value[VALUE_BITS-1:0];
  assign in_wclamp = (in_min_width > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : in_min_width;
  assign rd_idx    = DI'(nd_r - CW'(1));

  rna_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (state_r == ST_DIV_GO),
    .dividend  (mag_r),
    .divisor   (base_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = in_bad ? ST_ERR : ST_DIV_GO;
      ST_ERR:      if (ld) state_nxt = ST_IDLE;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_stat.done) state_nxt = (div_q == '0) ? ST_SIGN : ST_DIV_GO;
      ST_SIGN:     if (!sign_en_r || ld) state_nxt = ST_PRE0;
      ST_PRE0:     if (!pre_en_r || ld) state_nxt = ST_PRE1;
      ST_PRE1:     if (!pre_en_r || ld) state_nxt = ST_PAD;
      ST_PAD:      if (width_r <= nd_r) state_nxt = ST_DIG;
      ST_DIG:      if (ld && nd_r == CW'(1)) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // character offered to the output register
  always_comb begin
    emit_vld  = 1'b0;
    emit_ch   = CH_NUL;
    emit_last = 1'b0;
    emit_bad  = 1'b0;
    case (state_r)
      ST_ERR: begin
        emit_vld  = 1'b1;
        emit_last = 1'b1;
        emit_bad  = 1'b1;
      end
      ST_SIGN: begin
        emit_vld = sign_en_r;
        emit_ch  = sign_ch_r;
      end
      ST_PRE0: begin
        emit_vld = pre_en_r;
        emit_ch  = CH_ZERO;
      end
      ST_PRE1: begin
        emit_vld = pre_en_r;
        emit_ch  = pre_ch_r;
      end
      ST_PAD: begin
        emit_vld = (width_r > nd_r);
        emit_ch  = zfill_r ? CH_ZERO : CH_SPACE;
      end
      ST_DIG: begin
        emit_vld  = 1'b1;
        emit_ch   = digit_char(dig_r[rd_idx], upper_r);
        emit_last = (nd_r == CW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit_vld && ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_vld && ld) begin
      char_r <= emit_ch;
      last_r <= emit_last;
      bad_r  <= emit_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r     <= in_mag;
      base_r    <= in_radix[4:0];
      sign_en_r <= in_neg || (in_signed_mode && in_force_plus);
      sign_ch_r <= in_neg ? CH_MINUS : CH_PLUS;
      pre_en_r  <= in_show_prefix && (in_radix == 8'd2 || in_radix == 8'd8 ||
                                      in_radix == 8'd16);
      pre_ch_r  <= (in_radix == 8'd2) ? CH_B : ((in_radix == 8'd8) ? CH_O : CH_X);
      zfill_r   <= in_zero_fill;
      upper_r   <= in_upper_digits;
      width_r   <= CW'(in_wclamp);
      nd_r      <= '0;
    end else begin
      case (state_r)
        ST_DIV_WAIT: begin
          if (div_stat.done) begin
            dig_r[nd_r[DI-1:0]] <= div_rem;
            nd_r                <= nd_r + CW'(1);
            mag_r               <= div_q;
          end
        end
        ST_PAD: if (width_r > nd_r && ld) width_r <= width_r - CW'(1);
        ST_DIG: if (ld) nd_r <= nd_r - CW'(1);
        default: ;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = char_r;
  assign out_last_char = last_r;
  assign out_bad_radix = bad_r;

  `RNA_ASSERT(a_idle_div_quiet, in_ready |-> !div_stat.busy, "divider busy while idle")
  `RNA_ASSERT(a_bad_is_last,
              out_valid && out_bad_radix |-> out_last_char && out_char == CH_NUL,
              "error result malformed")
  `RNA_ASSERT(a_digit_bound, !in_ready |-> nd_r <= CW'(VALUE_BITS), "digit count past value width")
  `RNA_ASSERT(a_accept_blocks, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")

endmodule

[verif/tb.sv]
// Testbench for radix_number_to_ascii_core: random and directed numbers, each
// predicted as its expected character stream and checked one char per transaction.
// Depends on rna_pkg and the core RTL.
module tb;
  import rna_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int WIDTH_CAP = 32;
  localparam int RANDOM_PER_PHASE = 40;
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  radix;
    logic        signed_mode;
    logic [7:0]  min_width;
    logic        show_prefix;
    logic        zero_fill;
    logic        force_plus;
    logic        upper_digits;
  } number_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       bad;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_value = '0;
  logic [7:0]  in_radix = '0;
  logic        in_signed_mode = 1'b0;
  logic [7:0]  in_min_width = '0;
  logic        in_show_prefix = 1'b0;
  logic        in_zero_fill = 1'b0;
  logic        in_force_plus = 1'b0;
  logic        in_upper_digits = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_char;
  logic        out_last_char;
  logic        out_bad_radix;

  number_t    pending_numbers[$];
  text_char_t expected_chars[$];
  number_t    driven_number;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         error_count = 0;
  int         char_count = 0;
  int         cycle_count = 0;

  radix_number_to_ascii_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_signed_mode (in_signed_mode),
    .in_min_width   (in_min_width),
    .in_show_prefix (in_show_prefix),
    .in_zero_fill   (in_zero_fill),
    .in_force_plus  (in_force_plus),
    .in_upper_digits(in_upper_digits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .out_bad_radix  (out_bad_radix)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  function automatic logic [7:0] ascii_digit(input logic [3:0] d, input logic upper);
    if (d < 4'd10) return CH_ZERO + 8'(d);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
  endfunction

  // Expands one number into the characters the block should emit.
  task automatic format_number(input number_t n);
    logic [31:0] mag;
    logic [7:0]  digits[$];
    logic [7:0]  chars[$];
    int          width;
    text_char_t  c;
    if (n.radix < RADIX_MIN || n.radix > RADIX_MAX) begin
      c.ch = CH_NUL;
      c.last = 1'b1;
      c.bad = 1'b1;
      expected_chars.push_back(c);
      return;
    end
    width = (n.min_width > WIDTH_CAP) ? WIDTH_CAP : int'(n.min_width);
    mag = n.value;
    if (n.signed_mode && mag[31]) begin
      chars.push_back(CH_MINUS);
      mag = -mag;  // most negative value wraps to its exact magnitude
    end else if (n.signed_mode && n.force_plus) begin
      chars.push_back(CH_PLUS);
    end
    if (n.show_prefix) begin
      case (n.radix)
        8'd2: begin
          chars.push_back(CH_ZERO);
          chars.push_back(CH_B);
        end
        8'd8: begin
          chars.push_back(CH_ZERO);
          chars.push_back(CH_O);
        end
        8'd16: begin
          chars.push_back(CH_ZERO);
          chars.push_back(CH_X);
        end
        default: ;
      endcase
    end
    do begin
      digits.push_front(ascii_digit(4'(mag % n.radix), n.upper_digits));
      mag = mag / n.radix;
    end while (mag != 0);
    // padding goes between prefix and digits, spaces included
    for (int k = digits.size(); k < width; k++)
      chars.push_back(n.zero_fill ? CH_ZERO : CH_SPACE);
    foreach (digits[k]) chars.push_back(digits[k]);
    foreach (chars[k]) begin
      c.ch = chars[k];
      c.last = (k == chars.size() - 1);
      c.bad = 1'b0;
      expected_chars.push_back(c);
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH char %0d: %s got 0x%0h expected 0x%0h", char_count, what, got, want);
    error_count++;
  endtask

  function automatic number_t make_number(input logic [31:0] value, input logic [7:0] radix,
                                          input logic sgn, input logic [7:0] width,
                                          input logic [3:0] flags);
    number_t n;
    n.value = value;
    n.radix = radix;
    n.signed_mode = sgn;
    n.min_width = width;
    {n.show_prefix, n.zero_fill, n.force_plus, n.upper_digits} = flags;
    return n;
  endfunction

  function automatic number_t random_number();
    number_t n;
    n.value = $urandom();
    case ($urandom_range(0, 3))
      0: ;
      1: n.value = $urandom_range(0, 40);
      2: n.value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: n.value = -$urandom_range(1, 300);
    endcase
    n.radix = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(2, 16));
    if ($urandom_range(0, 2) == 0) n.radix = $urandom_range(0, 1) ? 8'd2 : 8'd16;
    n.min_width = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 36));
    n.signed_mode = 1'($urandom_range(0, 1));
    n.show_prefix = 1'($urandom_range(0, 1));
    n.zero_fill = 1'($urandom_range(0, 1));
    n.force_plus = 1'($urandom_range(0, 1));
    n.upper_digits = 1'($urandom_range(0, 1));
    return n;
  endfunction

  // Driver: loads the next number, unless it idles at random, when no number is offered or the current one is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) format_number(driven_number);
      if (!in_valid || in_ready) begin
        if (pending_numbers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_number = pending_numbers.pop_front();
          in_value <= driven_number.value;
          in_radix <= driven_number.radix;
          in_signed_mode <= driven_number.signed_mode;
          in_min_width <= driven_number.min_width;
          in_show_prefix <= driven_number.show_prefix;
          in_zero_fill <= driven_number.zero_fill;
          in_force_plus <= driven_number.force_plus;
          in_upper_digits <= driven_number.upper_digits;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction with the oldest expected char.
  always @(posedge clk) begin
    text_char_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected out_char", int'(out_char), 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch)
            report_mismatch("out_char", int'(out_char), int'(want.ch));
          if (out_last_char !== want.last)
            report_mismatch("out_last_char", int'(out_last_char), int'(want.last));
          if (out_bad_radix !== want.bad)
            report_mismatch("out_bad_radix", int'(out_bad_radix), int'(want.bad));
        end
        char_count++;
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      if (phase == 0) begin
        // flags: {show_prefix, zero_fill, force_plus, upper_digits}
        pending_numbers.push_back(make_number(32'd0, 8'd10, 1'b0, 8'd0, 4'b0000));
        pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd2, 1'b0, 8'd0, 4'b1000));
        pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd16, 1'b0, 8'd0, 4'b1001));
        pending_numbers.push_back(make_number(32'h8000_0000, 8'd10, 1'b1, 8'd0, 4'b0000));
        pending_numbers.push_back(make_number(32'h8000_0000, 8'd2, 1'b1, 8'd255, 4'b1100));
        pending_numbers.push_back(make_number(32'h7FFF_FFFF, 8'd16, 1'b1, 8'd0, 4'b1010));
        pending_numbers.push_back(make_number(32'd1234, 8'd0, 1'b0, 8'd0, 4'b0000));
        pending_numbers.push_back(make_number(32'd1234, 8'd1, 1'b0, 8'd0, 4'b0000));
        pending_numbers.push_back(make_number(32'd1234, 8'd17, 1'b1, 8'd5, 4'b1111));
        pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd255, 1'b1, 8'd255, 4'b1111));
        pending_numbers.push_back(make_number(32'o777, 8'd8, 1'b0, 8'd6, 4'b1100));
        pending_numbers.push_back(make_number(32'd99, 8'd10, 1'b0, 8'd8, 4'b1010));
        pending_numbers.push_back(make_number(32'd99, 8'd10, 1'b1, 8'd8, 4'b0010));
        pending_numbers.push_back(make_number(32'hDEAD_BEEF, 8'd16, 1'b0, 8'd2, 4'b1001));
        pending_numbers.push_back(make_number(32'hDEAD_BEEF, 8'd16, 1'b0, 8'd12, 4'b1000));
        pending_numbers.push_back(make_number(-32'd255, 8'd16, 1'b1, 8'd33, 4'b1000));
        pending_numbers.push_back(make_number(32'd255, 8'd16, 1'b0, 8'd32, 4'b0100));
        pending_numbers.push_back(make_number(32'd12345, 8'd3, 1'b0, 8'd0, 4'b1000));
        pending_numbers.push_back(make_number(32'hFFFF_FFFF, 8'd3, 1'b0, 8'd0, 4'b0000));
        pending_numbers.push_back(make_number(32'hABCD, 8'd15, 1'b0, 8'd0, 4'b0001));
        pending_numbers.push_back(make_number(-32'd1, 8'd7, 1'b1, 8'd4, 4'b0110));
        pending_numbers.push_back(make_number(32'd0, 8'd2, 1'b1, 8'd0, 4'b1110));
      end
      repeat (RANDOM_PER_PHASE) pending_numbers.push_back(random_number());
      while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
        @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && expected_chars.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/rna_pkg.sv
hdl/rna_divider.sv
hdl/radix_number_to_ascii_core.sv
verif/tb.sv
